### sv/ascii_decimal_to_fixed_point_core_macros.svh
// assertion macros for the ascii decimal to fixed point core
`ifndef ASCII_DECIMAL_TO_FIXED_POINT_CORE_MACROS_SVH
`define ASCII_DECIMAL_TO_FIXED_POINT_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ADFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ADFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/adfp_pkg.sv
// shared types, character codes and helpers for the decimal to fixed point core
package adfp_pkg;

   localparam int OUT_W = 48;

   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_PLUS  = 8'd43;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_DOT   = 8'd46;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_PLUS,
      PH_INT,
      PH_FRAC,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_POW,
      SEQ_DIV,
      SEQ_NEG,
      SEQ_OUT
   } seq_type;

   typedef enum logic [1:0] {
      ALU_MAC10,
      ALU_SHSUB,
      ALU_NEG
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [3:0] digit;
   } alu_ctl_type;

   function automatic logic [63:0] pow10(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

endpackage

### sv/adfp_alu.sv
// shared arithmetic unit: times ten plus digit, shift and subtract, negate
module adfp_alu #(
   parameter int W = 64
) (
   input  adfp_pkg::alu_ctl_type ctl,
   input  logic [W-1:0]          opa,
   input  logic [W-1:0]          opb,
   output logic [W-1:0]          res,
   output logic                  borrow
);
   import adfp_pkg::*;

   logic [W:0] diff;

   always_comb begin
      diff   = '0;
      res    = '0;
      borrow = 1'b0;
      case (ctl.op)
         ALU_MAC10: begin
            res = (opa << 3) + (opa << 1) + W'(ctl.digit);
         end
         ALU_SHSUB: begin
            diff   = {1'b0, opa << 1} - {1'b0, opb};
            res    = diff[W-1:0];
            borrow = diff[W];
         end
         ALU_NEG: begin
            res = W'(0) - opa;
         end
         default: begin
            res = '0;
         end
      endcase
   end

endmodule

### sv/ascii_decimal_to_fixed_point_core.sv
// top level: decimal string parser producing a signed fixed-point value
// each character is taken while idle, then parsed by an exec step through the shared unit
// after the last character, n times-ten steps build 10^n (n = kept fraction digits),
// then FRAC_BITS restoring division steps and one negate step form the response
// the single shared adder sets the rate; one character in flight, not ready meanwhile
// reset: synchronous, active high; returns to idle with an empty parse state
`include "ascii_decimal_to_fixed_point_core_macros.svh"

module ascii_decimal_to_fixed_point_core #(
   parameter int INT_BITS        = 32,
   parameter int FRAC_BITS       = 16,
   parameter int MAX_FRAC_DIGITS = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [47:0] value
   output logic [0:0]  rsp_tuser    // [0] overflow
);
   import adfp_pkg::*;

   localparam int IW = (INT_BITS - 1 < 47 - FRAC_BITS) ? INT_BITS - 1 : 47 - FRAC_BITS;
   localparam int DW = $clog2(pow10(MAX_FRAC_DIGITS));
   localparam int CW = $clog2(MAX_FRAC_DIGITS + 1);
   localparam int SW = $clog2(FRAC_BITS);
   localparam int UA = (IW + 4 > DW + 1) ? IW + 4 : DW + 1;
   localparam int UW = (UA > OUT_W) ? UA : OUT_W;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   seq_type        state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic           neg_ff, neg_in;
   logic           sat_ff, sat_in;
   logic [IW-1:0]  int_ff, int_in;
   logic [DW-1:0]  frac_ff, frac_in;       // fraction digits, then division remainder
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  pow_cnt_ff, pow_cnt_in;
   logic [SW-1:0]  step_ff, step_in;
   logic [7:0]     char_ff, char_in;
   logic           last_ff, last_in;
   logic [DW-1:0]  den_ff, den_in;
   logic [FRAC_BITS-1:0] q_ff, q_in;
   logic [OUT_W-1:0]     value_ff, value_in;

   alu_ctl_type    alu_ctl;
   logic [UW-1:0]  alu_a, alu_b, alu_res;
   logic           alu_borrow;
   logic           int_add, frac_add;
   logic [UW-1:0]  mag;
   logic [DW:0]    rem_shift;

   adfp_alu #(.W(UW)) u_alu (
      .ctl    (alu_ctl),
      .opa    (alu_a),
      .opb    (alu_b),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   assign mag       = (UW'(int_ff) << FRAC_BITS) | UW'(q_ff);
   assign rem_shift = {frac_ff, 1'b0};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_tvalid) state_in = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            state_in = last_ff ? SEQ_POW : SEQ_IDLE;
         end
         SEQ_POW: begin
            if (pow_cnt_ff == cnt_ff) state_in = SEQ_DIV;
         end
         SEQ_DIV: begin
            if (step_ff == '0) state_in = SEQ_NEG;
         end
         SEQ_NEG: begin
            state_in = SEQ_OUT;
         end
         SEQ_OUT: begin
            if (rsp_tready) state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // parse step classification of the held character
   always_comb begin
      int_add  = 1'b0;
      frac_add = 1'b0;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      case (phase_ff)
         PH_SPACE: begin
            if (is_space(char_ff)) begin
               phase_in = PH_SPACE;
            end else if (char_ff == CHAR_PLUS) begin
               phase_in = PH_PLUS;
            end else if (char_ff == CHAR_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_INT;
            end else if (is_digit(char_ff)) begin
               int_add  = 1'b1;
               phase_in = PH_INT;
            end else if (char_ff == CHAR_DOT) begin
               phase_in = PH_FRAC;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_PLUS: begin
            if (is_digit(char_ff)) begin
               int_add  = 1'b1;
               phase_in = PH_INT;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_INT: begin
            if (is_digit(char_ff)) begin
               int_add = 1'b1;
            end else if (char_ff == CHAR_DOT) begin
               phase_in = PH_FRAC;
            end else begin
               phase_in = PH_DONE;
            end
         end
         PH_FRAC: begin
            if (is_digit(char_ff)) begin
               frac_add = 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      req_tready = 1'b0;
      alu_ctl    = '{op: ALU_MAC10, digit: 4'd0};
      alu_a      = '0;
      alu_b      = '0;
      sat_in     = sat_ff;
      int_in     = int_ff;
      frac_in    = frac_ff;
      cnt_in     = cnt_ff;
      pow_cnt_in = pow_cnt_ff;
      step_in    = step_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      den_in     = den_ff;
      q_in       = q_ff;
      value_in   = value_ff;
      case (state_ff)
         SEQ_IDLE: begin
            req_tready = 1'b1;
            char_in    = req_tdata;
            last_in    = req_tlast;
         end
         SEQ_EXEC: begin
            alu_ctl = '{op: ALU_MAC10, digit: char_ff[3:0]};
            alu_a   = frac_add ? UW'(frac_ff) : UW'(int_ff);
            if (int_add && !sat_ff) begin
               // anything past IW bits means the integer part saturates
               if (alu_res[UW-1:IW] != '0) begin
                  int_in = '1;
                  sat_in = 1'b1;
               end else begin
                  int_in = alu_res[IW-1:0];
               end
            end
            if (frac_add && (cnt_ff < CW'(MAX_FRAC_DIGITS))) begin
               frac_in = alu_res[DW-1:0];
               cnt_in  = cnt_ff + CW'(1);
            end
            den_in     = DW'(1);
            pow_cnt_in = '0;
         end
         SEQ_POW: begin
            alu_ctl = '{op: ALU_MAC10, digit: 4'd0};
            alu_a   = UW'(den_ff);
            if (pow_cnt_ff != cnt_ff) begin
               den_in     = alu_res[DW-1:0];
               pow_cnt_in = pow_cnt_ff + CW'(1);
            end else begin
               step_in = SW'(FRAC_BITS - 1);
            end
         end
         SEQ_DIV: begin
            // restoring division, one quotient bit per cycle
            alu_ctl = '{op: ALU_SHSUB, digit: 4'd0};
            alu_a   = UW'(frac_ff);
            alu_b   = UW'(den_ff);
            frac_in = alu_borrow ? rem_shift[DW-1:0] : alu_res[DW-1:0];
            q_in    = {q_ff[FRAC_BITS-2:0], ~alu_borrow};
            step_in = step_ff - SW'(1);
         end
         SEQ_NEG: begin
            alu_ctl  = '{op: ALU_NEG, digit: 4'd0};
            alu_a    = mag;
            value_in = neg_ff ? alu_res[OUT_W-1:0] : mag[OUT_W-1:0];
         end
         SEQ_OUT: begin
            if (rsp_tready) begin
               sat_in  = 1'b0;
               int_in  = '0;
               frac_in = '0;
               cnt_in  = '0;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         phase_ff <= PH_SPACE;
         neg_ff   <= 1'b0;
         sat_ff   <= 1'b0;
         int_ff   <= '0;
         frac_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sat_ff   <= sat_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         cnt_ff   <= cnt_in;
         if (state_ff == SEQ_EXEC) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
         end else if ((state_ff == SEQ_OUT) && rsp_tready) begin
            phase_ff <= PH_SPACE;
            neg_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      char_ff    <= char_in;
      last_ff    <= last_in;
      den_ff     <= den_in;
      pow_cnt_ff <= pow_cnt_in;
      step_ff    <= step_in;
      q_ff       <= q_in;
      value_ff   <= value_in;
   end

   assign rsp_tvalid   = (state_ff == SEQ_OUT);
   assign rsp_tdata    = value_ff;
   assign rsp_tuser[0] = sat_ff;

   `ADFP_ASSERT_NOW(a_no_overlap, rsp_tvalid, !req_tready, "request taken while response pending")
   `ADFP_ASSERT_NOW(a_sat_max, sat_ff, int_ff == '1, "saturated integer part not at maximum")
   `ADFP_ASSERT_NOW(a_cnt_max, 1'b1, cnt_ff <= CW'(MAX_FRAC_DIGITS), "fraction digit count too high")
   `ADFP_ASSERT_NEXT(a_clear, rsp_tvalid && rsp_tready,
      (phase_ff == PH_SPACE) && !sat_ff && (cnt_ff == '0), "parse state not cleared")

endmodule
